@@ hdl/lin_pkg.sv @@
`timescale 1ns / 1ps

package lin_pkg;

    localparam int unsigned IDX_W      = 11;
    localparam int unsigned RANGE_W    = 16;
    localparam int unsigned RAW_W      = 16;
    localparam int unsigned PIX_W      = 14;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 20;

    localparam int unsigned BEAMS     = 1080;
    localparam int unsigned FULL_TURN = 1440;
    localparam int unsigned QUARTER   = 360;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOUNT      = 3'd0,
        CFG_SCALE      = 3'd1,
        CFG_ORG_X      = 3'd2,
        CFG_ORG_Y      = 3'd3,
        CFG_FULL_SCALE = 3'd4
    } cfg_reg_t;

    localparam logic [8:0]  MOUNT_RST      = 9'd135;
    localparam logic [15:0] SCALE_RST      = 16'd6554;
    localparam logic [9:0]  ORG_RST        = 10'd320;
    localparam logic [19:0] FULL_SCALE_RST = 20'd200000;

    // sine polynomial coefficients, Q30
    localparam logic [30:0] C1 = 31'd1686629713;
    localparam logic [30:0] C3 = 31'd693598668;
    localparam logic [30:0] C5 = 31'd85569306;
    localparam logic [30:0] C7 = 31'd5026995;
    localparam logic [30:0] C9 = 31'd172272;

    // t = r * 2^30 / 360 as r * T_RECIP + ((r * T_CORR) >> T_CORR_SH)
    localparam logic [31:0] T_RECIP   = 32'd2982616;
    localparam logic [31:0] T_CORR    = 32'd46608;
    localparam int unsigned T_CORR_SH = 18;

    localparam logic [31:0] K0287 = 32'd18809;
    localparam logic [31:0] K0196 = 32'd12845;

    function automatic logic [30:0] exp2_tab(input logic [3:0] k);
        logic [30:0] v;
        case (k)
            4'd0:    v = 31'd1518500250;
            4'd1:    v = 31'd1276901417;
            4'd2:    v = 31'd1170868978;
            4'd3:    v = 31'd1121280948;
            4'd4:    v = 31'd1097253709;
            4'd5:    v = 31'd1085434106;
            4'd6:    v = 31'd1079572136;
            4'd7:    v = 31'd1076653033;
            4'd8:    v = 31'd1075196443;
            4'd9:    v = 31'd1074468888;
            4'd10:   v = 31'd1074105295;
            4'd11:   v = 31'd1073923544;
            4'd12:   v = 31'd1073832680;
            4'd13:   v = 31'd1073787251;
            4'd14:   v = 31'd1073764537;
            default: v = 31'd1073753181;
        endcase
        return v;
    endfunction

    // log2 in Q16, evaluated at elaboration only
    function automatic logic [21:0] log2q_const(input logic [63:0] v);
        logic [5:0]  e;
        logic [63:0] m;
        logic [63:0] sq;
        logic [15:0] fr;
        e  = '0;
        fr = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                e = 6'(i);
            end
        end
        m = (v << (6'd63 - e)) >> 33;
        for (int k = 15; k >= 0; k--)
        begin
            sq = (m * m) >> 30;
            if (sq[31])
            begin
                fr[k] = 1'b1;
                m = sq >> 1;
            end
            else
            begin
                m = sq;
            end
        end
        return {e, fr};
    endfunction

    localparam logic [21:0] L255 = log2q_const(64'd255);

endpackage

@@ hdl/lin_in_if.sv @@
`timescale 1ns / 1ps

interface lin_in_if;
    logic                          valid;
    logic                          ready;
    logic [lin_pkg::IDX_W-1:0]     beam_index;
    logic [lin_pkg::RANGE_W-1:0]   range_mm;
    logic [lin_pkg::RAW_W-1:0]     raw_intensity;

    modport source (output valid, beam_index, range_mm, raw_intensity, input ready);
    modport sink   (input valid, beam_index, range_mm, raw_intensity, output ready);
endinterface

@@ hdl/lin_out_if.sv @@
`timescale 1ns / 1ps

interface lin_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [lin_pkg::PIX_W-1:0]   pixel_x;
    logic signed [lin_pkg::PIX_W-1:0]   pixel_y;
    logic [lin_pkg::LEVEL_W-1:0]        level;

    modport source (output valid, pixel_x, pixel_y, level, input ready);
    modport sink   (input valid, pixel_x, pixel_y, level, output ready);
endinterface

@@ hdl/lin_cfg_if.sv @@
`timescale 1ns / 1ps

interface lin_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lin_pkg::CFG_IDX_W-1:0]    index;
    logic [lin_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/lidar_intensity_normalizer.sv @@
`timescale 1ns / 1ps
// lidar beam intensity normalizer
// beam_in takes one beam (index, range, raw intensity); pix_out gives one
// result per beam: the rounded pixel of the point and its level 0..255.
// cfg register writes are to be made only while the block is idle; the block
// does not enforce this. cfg.ready is always high and an index past the last
// register is ignored. one beam is worked at a time: beam_in.ready is high
// only when no beam is in progress. a beam's time from transfer to result is
// set by the single shared 32x32 multiplier: sine and cosine need six
// products each, and the log2 unit squares sixteen times per logarithm, with
// up to five logarithms and sixteen exp2 products per beam.
// the result sits in an output register; the next beam is taken while it
// waits, and a finished beam holds in its last step until pix_out is free,
// so a stalled receiver stalls the block without loss.
// reset (rst_n low, asynchronous) restores the register defaults, clears the
// previous pixel to (0,0) and empties the output register.
module lidar_intensity_normalizer #(
    parameter int unsigned BEAMS = lin_pkg::BEAMS
) (
    input  logic         clk,
    input  logic         rst_n,
    lin_in_if.sink       beam_in,
    lin_out_if.source    pix_out,
    lin_cfg_if.sink      cfg
);

    typedef enum logic [5:0] {
        S_IDLE, S_MOD, S_SIN_SETUP, S_T2, S_T2W, S_P, S_PW, S_V, S_VW,
        S_PL, S_PLW, S_X, S_XW, S_YW,
        S_G0, S_G1, S_G2, S_G3, S_G4, S_G5, S_G6, S_G7,
        S_D1, S_D2, S_D3, S_D4,
        S_LV0, S_LV1, S_LV2, S_LV3, S_LV4, S_LV5,
        S_EX0, S_EX1, S_EX2, S_EX3,
        S_LG_NORM, S_LG_SQ, S_LG_SQW, S_FIN
    } state_t;

    // control and configuration
    state_t             state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [13:0] out_x_reg, out_x_next;
    logic signed [13:0] out_y_reg, out_y_next;
    logic [7:0]         out_level_reg, out_level_next;
    logic signed [13:0] prev_x_reg, prev_x_next;
    logic signed [13:0] prev_y_reg, prev_y_next;
    logic [8:0]         mount_reg, mount_next;
    logic [15:0]        scale_reg, scale_next;
    logic [9:0]         ox_reg, ox_next;
    logic [9:0]         oy_reg, oy_next;
    logic [19:0]        fs_reg, fs_next;

    // datapath
    logic [10:0]        idx_reg, idx_next;
    logic [15:0]        range_reg, range_next;
    logic [15:0]        raw_reg, raw_next;
    logic [12:0]        q_reg, q_next;
    logic               sel_reg, sel_next;
    logic               neg_reg, neg_next;
    logic [30:0]        t_reg, t_next;
    logic [30:0]        t2_reg, t2_next;
    logic [30:0]        p_reg, p_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [16:0]        s_mag_reg, s_mag_next;
    logic               s_neg_reg, s_neg_next;
    logic [16:0]        c_mag_reg, c_mag_next;
    logic               c_neg_reg, c_neg_next;
    logic [31:0]        pp_reg, pp_next;
    logic signed [13:0] x_reg, x_next;
    logic signed [13:0] y_reg, y_next;
    logic [28:0]        a2_reg, a2_next;
    logic [29:0]        b2_reg, b2_next;
    logic signed [30:0] cr_reg, cr_next;
    logic               zdiv_reg, zdiv_next;
    logic [63:0]        lv_reg, lv_next;
    logic [5:0]         lsh_reg, lsh_next;
    logic [5:0]         le_reg, le_next;
    logic [30:0]        lm_reg, lm_next;
    logic [15:0]        lfr_reg, lfr_next;
    logic [3:0]         lcnt_reg, lcnt_next;
    state_t             lret_reg, lret_next;
    logic signed [22:0] d_reg, d_next;
    logic signed [25:0] lacc_reg, lacc_next;
    logic [30:0]        em_reg, em_next;
    logic [3:0]         en_reg, en_next;
    logic [15:0]        efr_reg, efr_next;
    logic [7:0]         level_reg, level_next;
    logic [63:0]        prod_reg, prod_next;

    logic [31:0]        mul_a, mul_b;

    logic [10:0]        aidx;
    logic signed [13:0] qa;
    logic [11:0]        ang_sum;
    logic [10:0]        ang;
    logic [1:0]         quad;
    logic [8:0]         rem;
    logic [8:0]         rr;
    logic [32:0]        vsum;
    logic [18:0]        vq;
    logic [16:0]        vmag;
    logic signed [14:0] ax, ay, bx, by;
    logic [14:0]        ax_m, ay_m, bx_m, by_m;
    logic [30:0]        cr_m;
    logic signed [30:0] term;
    logic [31:0]        sq;
    logic [21:0]        lres;
    logic signed [25:0] lres26;
    logic signed [22:0] dd;
    logic [37:0]        rnd287;
    logic [38:0]        rnd196;
    logic signed [25:0] u26;
    logic [39:0]        esh;
    logic [40:0]        eround;

    function automatic logic [14:0] abs15(input logic signed [14:0] v);
        return v[14] ? 15'(-v) : 15'(v);
    endfunction

    // origin + round-half-even(mag / 2^32) with sign, saturated to 14 bits
    function automatic logic signed [13:0] place(input logic [63:0] mag, input logic neg,
                                                 input logic [9:0] org);
        logic [17:0]        ip;
        logic [31:0]        fr;
        logic signed [19:0] v;
        logic signed [13:0] r;
        ip = {1'b0, mag[48:32]};
        fr = mag[31:0];
        if (fr > 32'h8000_0000 || (fr == 32'h8000_0000 && ip[0]))
        begin
            ip = ip + 18'd1;
        end
        v = neg ? -$signed({2'b00, ip}) : $signed({2'b00, ip});
        v = v + $signed({10'b0, org});
        if (v > 20'sd8191)
        begin
            r = 14'sd8191;
        end
        else if (v < -20'sd8192)
        begin
            r = -14'sd8192;
        end
        else
        begin
            r = 14'(v);
        end
        return r;
    endfunction

    assign beam_in.ready   = (state_reg == S_IDLE);
    assign cfg.ready       = 1'b1;
    assign pix_out.valid   = out_valid_reg;
    assign pix_out.pixel_x = out_x_reg;
    assign pix_out.pixel_y = out_y_reg;
    assign pix_out.level   = out_level_reg;

    always_comb
    begin
        aidx = (32'(beam_in.beam_index) >= BEAMS) ? 11'(BEAMS - 1)
                                                  : beam_in.beam_index;
        qa = $signed({3'b000, aidx}) + $signed({{3{mount_reg[8]}}, mount_reg, 2'b00})
             + 14'(lin_pkg::FULL_TURN);

        ang_sum = {1'b0, q_reg[10:0]} + 12'(lin_pkg::QUARTER);
        if (!sel_reg)
        begin
            ang = q_reg[10:0];
        end
        else if (ang_sum >= 12'(lin_pkg::FULL_TURN))
        begin
            ang = 11'(ang_sum - 12'(lin_pkg::FULL_TURN));
        end
        else
        begin
            ang = ang_sum[10:0];
        end
        if (ang >= 11'(3 * lin_pkg::QUARTER))
        begin
            quad = 2'd3;
            rem  = 9'(ang - 11'(3 * lin_pkg::QUARTER));
        end
        else if (ang >= 11'(2 * lin_pkg::QUARTER))
        begin
            quad = 2'd2;
            rem  = 9'(ang - 11'(2 * lin_pkg::QUARTER));
        end
        else if (ang >= 11'(lin_pkg::QUARTER))
        begin
            quad = 2'd1;
            rem  = 9'(ang - 11'(lin_pkg::QUARTER));
        end
        else
        begin
            quad = 2'd0;
            rem  = ang[8:0];
        end
        rr = quad[0] ? 9'(9'(lin_pkg::QUARTER) - rem) : rem;

        vsum = {1'b0, prod_reg[61:30]} + 33'd8192;
        vq   = vsum[32:14];
        vmag = (vq > 19'd65536) ? 17'd65536 : vq[16:0];

        ax = $signed({5'b00000, ox_reg}) - $signed({x_reg[13], x_reg});
        ay = $signed({5'b00000, oy_reg}) - $signed({y_reg[13], y_reg});
        bx = $signed({prev_x_reg[13], prev_x_reg}) - $signed({x_reg[13], x_reg});
        by = $signed({prev_y_reg[13], prev_y_reg}) - $signed({y_reg[13], y_reg});
        ax_m = abs15(ax);
        ay_m = abs15(ay);
        bx_m = abs15(bx);
        by_m = abs15(by);
        cr_m = cr_reg[30] ? 31'(-cr_reg) : 31'(cr_reg);
        term = $signed({1'b0, prod_reg[29:0]});

        sq     = prod_reg[61:30];
        lres   = {le_reg, lfr_reg};
        lres26 = $signed({4'b0000, lres});
        dd     = d_reg - $signed({1'b0, lres});
        rnd287 = prod_reg[37:0] + 38'd32768;
        rnd196 = prod_reg[38:0] + 39'd65536;
        u26    = lacc_reg + 26'sd131072;
        esh    = {9'b0, em_reg} << en_reg;
        eround = {1'b0, esh} + 41'h0_8000_0000;

        case (state_reg)
            S_T2:    begin mul_a = {1'b0, t_reg};  mul_b = {1'b0, t_reg};  end
            S_P:     begin mul_a = {1'b0, p_reg};  mul_b = {1'b0, t2_reg}; end
            S_V:     begin mul_a = {1'b0, p_reg};  mul_b = {1'b0, t_reg};  end
            S_PL:    begin mul_a = 32'(range_reg); mul_b = 32'(scale_reg); end
            S_X:     begin mul_a = pp_reg;         mul_b = 32'(s_mag_reg); end
            S_XW:    begin mul_a = pp_reg;         mul_b = 32'(c_mag_reg); end
            S_G0:    begin mul_a = 32'(ax_m);      mul_b = 32'(ax_m);      end
            S_G1:    begin mul_a = 32'(ay_m);      mul_b = 32'(ay_m);      end
            S_G2:    begin mul_a = 32'(bx_m);      mul_b = 32'(bx_m);      end
            S_G3:    begin mul_a = 32'(by_m);      mul_b = 32'(by_m);      end
            S_G4:    begin mul_a = 32'(ax_m);      mul_b = 32'(by_m);      end
            S_G5:    begin mul_a = 32'(ay_m);      mul_b = 32'(bx_m);      end
            S_G7:    begin mul_a = 32'(a2_reg);    mul_b = 32'(b2_reg);    end
            S_D2:    begin mul_a = {1'b0, cr_m};   mul_b = {1'b0, cr_m};   end
            S_LG_SQ: begin mul_a = {1'b0, lm_reg}; mul_b = {1'b0, lm_reg}; end
            S_LV1:   begin mul_a = 32'(lres);      mul_b = lin_pkg::K0287; end
            S_LV2:   begin mul_a = 32'(d_reg[21:0]); mul_b = lin_pkg::K0196; end
            S_EX1:
            begin
                mul_a = {1'b0, em_reg};
                mul_b = {1'b0, lin_pkg::exp2_tab(cnt_reg)};
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
        prod_next = 64'(mul_a) * 64'(mul_b);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_level_next = out_level_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        mount_next     = mount_reg;
        scale_next     = scale_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        fs_next        = fs_reg;
        idx_next       = idx_reg;
        range_next     = range_reg;
        raw_next       = raw_reg;
        q_next         = q_reg;
        sel_next       = sel_reg;
        neg_next       = neg_reg;
        t_next         = t_reg;
        t2_next        = t2_reg;
        p_next         = p_reg;
        cnt_next       = cnt_reg;
        s_mag_next     = s_mag_reg;
        s_neg_next     = s_neg_reg;
        c_mag_next     = c_mag_reg;
        c_neg_next     = c_neg_reg;
        pp_next        = pp_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        a2_next        = a2_reg;
        b2_next        = b2_reg;
        cr_next        = cr_reg;
        zdiv_next      = zdiv_reg;
        lv_next        = lv_reg;
        lsh_next       = lsh_reg;
        le_next        = le_reg;
        lm_next        = lm_reg;
        lfr_next       = lfr_reg;
        lcnt_next      = lcnt_reg;
        lret_next      = lret_reg;
        d_next         = d_reg;
        lacc_next      = lacc_reg;
        em_next        = em_reg;
        en_next        = en_reg;
        efr_next       = efr_reg;
        level_next     = level_reg;

        if (cfg.valid)
        begin
            case (cfg.index)
                lin_pkg::CFG_MOUNT:      mount_next = cfg.data[8:0];
                lin_pkg::CFG_SCALE:      scale_next = cfg.data[15:0];
                lin_pkg::CFG_ORG_X:      ox_next    = cfg.data[9:0];
                lin_pkg::CFG_ORG_Y:      oy_next    = cfg.data[9:0];
                lin_pkg::CFG_FULL_SCALE: fs_next    = cfg.data;
                default: ;
            endcase
        end

        if (pix_out.valid && pix_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (beam_in.valid)
                begin
                    idx_next   = beam_in.beam_index;
                    range_next = beam_in.range_mm;
                    raw_next   = beam_in.raw_intensity;
                    q_next     = qa[12:0];
                    sel_next   = 1'b0;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (q_reg >= 13'(lin_pkg::FULL_TURN))
                begin
                    q_next = q_reg - 13'(lin_pkg::FULL_TURN);
                end
                else
                begin
                    state_next = S_SIN_SETUP;
                end
            end
            S_SIN_SETUP:
            begin
                neg_next   = quad[1];
                t_next     = 31'(32'(rr) * lin_pkg::T_RECIP
                                 + ((32'(rr) * lin_pkg::T_CORR) >> lin_pkg::T_CORR_SH));
                state_next = S_T2;
            end
            S_T2:
            begin
                state_next = S_T2W;
            end
            S_T2W:
            begin
                t2_next    = prod_reg[60:30];
                p_next     = lin_pkg::C9;
                cnt_next   = '0;
                state_next = S_P;
            end
            S_P:
            begin
                state_next = S_PW;
            end
            S_PW:
            begin
                case (cnt_reg[1:0])
                    2'd0:    p_next = 31'({1'b0, lin_pkg::C7} - prod_reg[61:30]);
                    2'd1:    p_next = 31'({1'b0, lin_pkg::C5} - prod_reg[61:30]);
                    2'd2:    p_next = 31'({1'b0, lin_pkg::C3} - prod_reg[61:30]);
                    default: p_next = 31'({1'b0, lin_pkg::C1} - prod_reg[61:30]);
                endcase
                cnt_next   = cnt_reg + 4'd1;
                state_next = (cnt_reg == 4'd3) ? S_V : S_P;
            end
            S_V:
            begin
                state_next = S_VW;
            end
            S_VW:
            begin
                if (!sel_reg)
                begin
                    s_mag_next = vmag;
                    s_neg_next = neg_reg;
                    sel_next   = 1'b1;
                    state_next = S_SIN_SETUP;
                end
                else
                begin
                    c_mag_next = vmag;
                    c_neg_next = neg_reg;
                    state_next = S_PL;
                end
            end
            S_PL:
            begin
                state_next = S_PLW;
            end
            S_PLW:
            begin
                pp_next    = prod_reg[31:0];
                state_next = S_X;
            end
            S_X:
            begin
                state_next = S_XW;
            end
            S_XW:
            begin
                x_next     = place(prod_reg, s_neg_reg, ox_reg);
                state_next = S_YW;
            end
            S_YW:
            begin
                y_next     = place(prod_reg, c_neg_reg, oy_reg);
                state_next = S_G0;
            end
            S_G0:
            begin
                state_next = S_G1;
            end
            S_G1:
            begin
                a2_next    = prod_reg[28:0];
                state_next = S_G2;
            end
            S_G2:
            begin
                a2_next    = a2_reg + prod_reg[28:0];
                state_next = S_G3;
            end
            S_G3:
            begin
                b2_next    = prod_reg[29:0];
                state_next = S_G4;
            end
            S_G4:
            begin
                b2_next    = b2_reg + prod_reg[29:0];
                state_next = S_G5;
            end
            S_G5:
            begin
                cr_next    = (ax[14] ^ by[14]) ? -term : term;
                state_next = S_G6;
            end
            S_G6:
            begin
                cr_next    = (ay[14] ^ bx[14]) ? cr_reg + term : cr_reg - term;
                state_next = S_G7;
            end
            S_G7:
            begin
                zdiv_next = 1'b0;
                d_next    = '0;
                if (idx_reg == '0 || a2_reg == '0 || b2_reg == '0)
                begin
                    state_next = S_LV0;
                end
                else if (cr_reg == '0)
                begin
                    zdiv_next  = 1'b1;
                    state_next = S_LV0;
                end
                else
                begin
                    state_next = S_D1;
                end
            end
            S_D1:
            begin
                lv_next    = prod_reg;
                lsh_next   = '0;
                lfr_next   = '0;
                lcnt_next  = 4'd15;
                lret_next  = S_D2;
                state_next = S_LG_NORM;
            end
            S_D2:
            begin
                d_next     = $signed({1'b0, lres});
                state_next = S_D3;
            end
            S_D3:
            begin
                lv_next    = prod_reg;
                lsh_next   = '0;
                lfr_next   = '0;
                lcnt_next  = 4'd15;
                lret_next  = S_D4;
                state_next = S_LG_NORM;
            end
            S_D4:
            begin
                d_next     = dd[22] ? '0 : dd;
                state_next = S_LV0;
            end
            S_LV0:
            begin
                if (zdiv_reg || fs_reg == '0)
                begin
                    level_next = 8'hFF;
                    state_next = S_FIN;
                end
                else if (raw_reg == '0 || range_reg == '0)
                begin
                    level_next = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    lv_next    = 64'(range_reg);
                    lsh_next   = '0;
                    lfr_next   = '0;
                    lcnt_next  = 4'd15;
                    lret_next  = S_LV1;
                    state_next = S_LG_NORM;
                end
            end
            S_LV1:
            begin
                state_next = S_LV2;
            end
            S_LV2:
            begin
                lacc_next  = $signed({4'b0000, rnd287[37:16]});
                state_next = S_LV3;
            end
            S_LV3:
            begin
                lacc_next  = lacc_reg + $signed({4'b0000, rnd196[38:17]});
                lv_next    = 64'(raw_reg);
                lsh_next   = '0;
                lfr_next   = '0;
                lcnt_next  = 4'd15;
                lret_next  = S_LV4;
                state_next = S_LG_NORM;
            end
            S_LV4:
            begin
                lacc_next  = lacc_reg + lres26 + $signed({4'b0000, lin_pkg::L255});
                lv_next    = 64'(fs_reg);
                lsh_next   = '0;
                lfr_next   = '0;
                lcnt_next  = 4'd15;
                lret_next  = S_LV5;
                state_next = S_LG_NORM;
            end
            S_LV5:
            begin
                lacc_next  = lacc_reg - lres26;
                state_next = S_EX0;
            end
            S_EX0:
            begin
                if (lacc_reg >= 26'sd524288)
                begin
                    level_next = 8'hFF;
                    state_next = S_FIN;
                end
                else if (lacc_reg < -26'sd131072)
                begin
                    level_next = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    en_next    = u26[19:16];
                    efr_next   = u26[15:0];
                    em_next    = 31'h4000_0000;
                    cnt_next   = '0;
                    state_next = S_EX1;
                end
            end
            S_EX1:
            begin
                if (efr_reg[4'd15 - cnt_reg])
                begin
                    state_next = S_EX2;
                end
                else if (cnt_reg == 4'd15)
                begin
                    state_next = S_EX3;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            S_EX2:
            begin
                em_next = prod_reg[60:30];
                if (cnt_reg == 4'd15)
                begin
                    state_next = S_EX3;
                end
                else
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = S_EX1;
                end
            end
            S_EX3:
            begin
                level_next = (eround[40:32] > 9'd255) ? 8'hFF : eround[39:32];
                state_next = S_FIN;
            end
            S_LG_NORM:
            begin
                if (lv_reg[63])
                begin
                    le_next    = 6'd63 - lsh_reg;
                    lm_next    = lv_reg[63:33];
                    state_next = S_LG_SQ;
                end
                else if (lv_reg[63:56] == '0)
                begin
                    lv_next  = lv_reg << 8;
                    lsh_next = lsh_reg + 6'd8;
                end
                else
                begin
                    lv_next  = lv_reg << 1;
                    lsh_next = lsh_reg + 6'd1;
                end
            end
            S_LG_SQ:
            begin
                state_next = S_LG_SQW;
            end
            S_LG_SQW:
            begin
                if (sq[31])
                begin
                    lfr_next[lcnt_reg] = 1'b1;
                    lm_next = sq[31:1];
                end
                else
                begin
                    lm_next = sq[30:0];
                end
                if (lcnt_reg == '0)
                begin
                    state_next = lret_reg;
                end
                else
                begin
                    lcnt_next  = lcnt_reg - 4'd1;
                    state_next = S_LG_SQ;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || pix_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = x_reg;
                    out_y_next     = y_reg;
                    out_level_next = level_reg;
                    prev_x_next    = x_reg;
                    prev_y_next    = y_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_level_reg <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            mount_reg     <= lin_pkg::MOUNT_RST;
            scale_reg     <= lin_pkg::SCALE_RST;
            ox_reg        <= lin_pkg::ORG_RST;
            oy_reg        <= lin_pkg::ORG_RST;
            fs_reg        <= lin_pkg::FULL_SCALE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_level_reg <= out_level_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            mount_reg     <= mount_next;
            scale_reg     <= scale_next;
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
            fs_reg        <= fs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        range_reg <= range_next;
        raw_reg   <= raw_next;
        q_reg     <= q_next;
        sel_reg   <= sel_next;
        neg_reg   <= neg_next;
        t_reg     <= t_next;
        t2_reg    <= t2_next;
        p_reg     <= p_next;
        cnt_reg   <= cnt_next;
        s_mag_reg <= s_mag_next;
        s_neg_reg <= s_neg_next;
        c_mag_reg <= c_mag_next;
        c_neg_reg <= c_neg_next;
        pp_reg    <= pp_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        a2_reg    <= a2_next;
        b2_reg    <= b2_next;
        cr_reg    <= cr_next;
        zdiv_reg  <= zdiv_next;
        lv_reg    <= lv_next;
        lsh_reg   <= lsh_next;
        le_reg    <= le_next;
        lm_reg    <= lm_next;
        lfr_reg   <= lfr_next;
        lcnt_reg  <= lcnt_next;
        lret_reg  <= lret_next;
        d_reg     <= d_next;
        lacc_reg  <= lacc_next;
        em_reg    <= em_next;
        en_reg    <= en_next;
        efr_reg   <= efr_next;
        level_reg <= level_next;
        prod_reg  <= prod_next;
    end

`ifndef SYNTHESIS
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (beam_in.valid && beam_in.ready) |=> (state_reg != S_IDLE))
        else $error("beam transfer did not start the sequencer");

    a_log_mantissa_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LG_SQ) |-> lm_reg[30])
        else $error("log2 mantissa lost its leading one");

    a_zero_full_scale_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && fs_reg == '0) |-> (level_reg == 8'hFF))
        else $error("zero full scale did not saturate the level");
`endif

endmodule
